FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("Same-cycle check failed.");

// The consequent must hold in the cycle after the antecedent.
`define PTT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");

`endif

FILE: hdl/ptt_pkg.sv
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MAX_OUT   = 16;
    localparam int CNT_W     = $clog2(MAX_OUT + 1);
    localparam int ID_W      = 32;
    localparam int PER_W     = 24;
    localparam int TIME_W    = 32;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 64;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_FIRED     = 3'd0,
        KIND_ADDED     = 3'd1,
        KIND_REPLACED  = 3'd2,
        KIND_DELETED   = 3'd3,
        KIND_NOT_FOUND = 3'd4,
        KIND_FULL      = 3'd5,
        KIND_BAD_INTVL = 3'd6
    } kind_t;

endpackage

FILE: hdl/periodic_task_timer_table.sv
`timescale 1ns / 1ps

// Channel  Direction  tdata (low bit up)                           tuser    tlast
// s_       in         entry_id, period, first_offset, now_time     command  -
// m_       out        result_id, due_time                          kind     last
//
// Add and delete items take one slot pass, but an add with a zero period takes none.
// A tick takes one slot pass per fired entry, plus one more unless MAX_OUT entries fire,
// and each fired entry passes the bit-serial remainder unit that advances its due time.
// The block takes no item until every result of the current one has been taken.
// Reset empties the table at once and clears the current time to zero.
module periodic_task_timer_table_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ptt_pkg::IN_DATA_W-1:0]   s_tdata,  // entry_id, period, first_offset, now_time
    input  logic [1:0]                      s_tuser,  // command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ptt_pkg::OUT_DATA_W-1:0]  m_tdata,  // result_id, due_time
    output logic [2:0]                      m_tuser,  // kind
    output logic                            m_tlast
);
    import ptt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TSCAN, ST_TDECIDE, ST_TADV, ST_TDIV,
        ST_KSCAN, ST_KDECIDE, ST_WAIT
    } state_t;

    state_t state_reg, ret_reg;

    logic [NUM_SLOTS-1:0] valid_reg;
    logic [ID_W-1:0]   key_mem [NUM_SLOTS];
    logic [PER_W-1:0]  per_mem [NUM_SLOTS];
    logic [TIME_W-1:0] due_mem [NUM_SLOTS];

    logic [TIME_W-1:0] now_reg;
    cmd_t              cmd_reg;
    logic [ID_W-1:0]   id_reg;
    logic [PER_W-1:0]  per_reg;
    logic [PER_W-1:0]  ofs_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic              found_reg;
    logic [SLOT_W-1:0] best_reg;
    logic [TIME_W-1:0] best_due_reg;
    logic              free_reg;
    logic [SLOT_W-1:0] free_idx_reg;
    logic              pend_reg;
    logic [ID_W-1:0]   pend_id_reg;
    logic [TIME_W-1:0] pend_due_reg;
    logic [CNT_W-1:0]  n_reg;

    logic              out_valid_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [TIME_W-1:0] out_due_reg;
    kind_t             out_kind_reg;
    logic              out_last_reg;

    logic              is_last_idx;
    logic              cand;
    logic [TIME_W:0]   add_due;
    logic [TIME_W-1:0] add_due_sat;
    logic [TIME_W:0]   adv_due;
    logic [TIME_W-1:0] adv_due_sat;
    logic              rem_start;
    logic              rem_done;
    logic [PER_W-1:0]  rem_val;
    logic [TIME_W-1:0] rem_num;

    assign is_last_idx = (idx_reg == SLOT_W'(NUM_SLOTS - 1));
    assign cand = valid_reg[idx_reg] && (due_mem[idx_reg] <= now_reg) &&
                  (!found_reg || (due_mem[idx_reg] < best_due_reg));
    assign add_due     = {1'b0, now_reg} + {{(TIME_W - PER_W + 1){1'b0}}, ofs_reg};
    assign add_due_sat = add_due[TIME_W] ? '1 : add_due[TIME_W-1:0];
    assign adv_due     = {1'b0, now_reg} - {{(TIME_W - PER_W + 1){1'b0}}, rem_val}
                       + {{(TIME_W - PER_W + 1){1'b0}}, per_mem[best_reg]};
    assign adv_due_sat = adv_due[TIME_W] ? '1 : adv_due[TIME_W-1:0];
    assign rem_num     = now_reg - due_mem[best_reg];
    assign rem_start   = (state_reg == ST_TADV);

    ptt_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (rem_num),
        .divisor   (per_mem[best_reg]),
        .done      (rem_done),
        .remainder (rem_val)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            valid_reg     <= '0;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            n_reg         <= '0;
            idx_reg       <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg   <= cmd_t'(s_tuser);
                        id_reg    <= s_tdata[31:0];
                        per_reg   <= s_tdata[55:32];
                        ofs_reg   <= s_tdata[79:56];
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        free_reg  <= 1'b0;
                        pend_reg  <= 1'b0;
                        n_reg     <= '0;
                        case (cmd_t'(s_tuser))
                            CMD_TICK: begin
                                now_reg   <= s_tdata[111:80];
                                state_reg <= ST_TSCAN;
                            end
                            CMD_ADD: begin
                                if (s_tdata[55:32] == '0) begin
                                    out_valid_reg <= 1'b1;
                                    out_kind_reg  <= KIND_BAD_INTVL;
                                    out_id_reg    <= s_tdata[31:0];
                                    out_due_reg   <= '0;
                                    out_last_reg  <= 1'b1;
                                    ret_reg       <= ST_IDLE;
                                    state_reg     <= ST_WAIT;
                                end else begin
                                    state_reg <= ST_KSCAN;
                                end
                            end
                            CMD_DELETE: state_reg <= ST_KSCAN;
                            default:    state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_TSCAN: begin
                    if (cand) begin
                        found_reg    <= 1'b1;
                        best_reg     <= idx_reg;
                        best_due_reg <= due_mem[idx_reg];
                    end
                    if (is_last_idx) begin
                        idx_reg   <= '0;
                        state_reg <= ST_TDECIDE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_TDECIDE: begin
                    if (found_reg) begin
                        if (pend_reg) begin
                            out_valid_reg <= 1'b1;
                            out_kind_reg  <= KIND_FIRED;
                            out_id_reg    <= pend_id_reg;
                            out_due_reg   <= pend_due_reg;
                            out_last_reg  <= 1'b0;
                            ret_reg       <= ST_TADV;
                            state_reg     <= ST_WAIT;
                        end else begin
                            state_reg <= ST_TADV;
                        end
                    end else if (pend_reg) begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= KIND_FIRED;
                        out_id_reg    <= pend_id_reg;
                        out_due_reg   <= pend_due_reg;
                        out_last_reg  <= 1'b1;
                        ret_reg       <= ST_IDLE;
                        state_reg     <= ST_WAIT;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_TADV: begin
                    pend_reg     <= 1'b1;
                    pend_id_reg  <= key_mem[best_reg];
                    pend_due_reg <= due_mem[best_reg];
                    n_reg        <= n_reg + 1'b1;
                    state_reg    <= ST_TDIV;
                end
                ST_TDIV: begin
                    if (rem_done) begin
                        due_mem[best_reg] <= adv_due_sat;
                        found_reg         <= 1'b0;
                        if (n_reg == CNT_W'(MAX_OUT)) begin
                            out_valid_reg <= 1'b1;
                            out_kind_reg  <= KIND_FIRED;
                            out_id_reg    <= pend_id_reg;
                            out_due_reg   <= pend_due_reg;
                            out_last_reg  <= 1'b1;
                            ret_reg       <= ST_IDLE;
                            state_reg     <= ST_WAIT;
                        end else begin
                            state_reg <= ST_TSCAN;
                        end
                    end
                end
                ST_KSCAN: begin
                    if (valid_reg[idx_reg] && key_mem[idx_reg] == id_reg && !found_reg) begin
                        found_reg <= 1'b1;
                        best_reg  <= idx_reg;
                    end
                    if (!valid_reg[idx_reg] && !free_reg) begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= idx_reg;
                    end
                    if (is_last_idx) begin
                        idx_reg   <= '0;
                        state_reg <= ST_KDECIDE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_KDECIDE: begin
                    out_valid_reg <= 1'b1;
                    out_id_reg    <= id_reg;
                    out_due_reg   <= (cmd_reg == CMD_ADD && (found_reg || free_reg)) ?
                                     add_due_sat : '0;
                    out_last_reg  <= 1'b1;
                    ret_reg       <= ST_IDLE;
                    state_reg     <= ST_WAIT;
                    if (cmd_reg == CMD_ADD) begin
                        if (found_reg || free_reg) begin
                            valid_reg[found_reg ? best_reg : free_idx_reg] <= 1'b1;
                            key_mem[found_reg ? best_reg : free_idx_reg]   <= id_reg;
                            per_mem[found_reg ? best_reg : free_idx_reg]   <= per_reg;
                            due_mem[found_reg ? best_reg : free_idx_reg]   <= add_due_sat;
                            out_kind_reg <= found_reg ? KIND_REPLACED : KIND_ADDED;
                        end else begin
                            out_kind_reg <= KIND_FULL;
                        end
                    end else if (found_reg) begin
                        valid_reg[best_reg] <= 1'b0;
                        out_kind_reg        <= KIND_DELETED;
                    end else begin
                        out_kind_reg <= KIND_NOT_FOUND;
                    end
                end
                ST_WAIT: begin
                    if (m_tready) begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ret_reg;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_due_reg, out_id_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: hdl/ptt_rem.sv
`timescale 1ns / 1ps

module ptt_rem (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [ptt_pkg::TIME_W-1:0] dividend,
    input  logic [ptt_pkg::PER_W-1:0]  divisor,
    output logic                    done,
    output logic [ptt_pkg::PER_W-1:0]  remainder
);
    import ptt_pkg::*;

    localparam int STEP_W = $clog2(TIME_W + 1);

    logic [TIME_W-1:0] num_reg;
    logic [PER_W-1:0]  div_reg;
    logic [PER_W:0]    rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [PER_W:0]    trial;
    logic [PER_W:0]    diff;

    assign trial = {rem_reg[PER_W-1:0], num_reg[TIME_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= busy_reg && !start && (step_reg == STEP_W'(TIME_W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                num_reg  <= dividend;
                div_reg  <= divisor;
                rem_reg  <= '0;
                step_reg <= '0;
            end else if (busy_reg) begin
                num_reg <= {num_reg[TIME_W-2:0], 1'b0};
                if (!diff[PER_W]) begin
                    rem_reg <= diff;
                end else begin
                    rem_reg <= trial;
                end
                if (step_reg == STEP_W'(TIME_W - 1)) begin
                    busy_reg <= 1'b0;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[PER_W-1:0];

endmodule

FILE: hdl/ptt_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptt_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [1:0]                      s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [2:0]                      m_tuser,
    input logic                            m_tlast
);
    import ptt_pkg::*;

    `PTT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `PTT_ASSERT_SAME(a_ready_no_out, s_tready, !m_tvalid)
    `PTT_ASSERT_SAME(a_single_last, m_tvalid && m_tuser != KIND_FIRED, m_tlast)
    `PTT_ASSERT_NEXT(a_busy_after, s_tvalid && s_tready && s_tuser != CMD_NONE, !s_tready)

endmodule

bind periodic_task_timer_table_core ptt_checker u_ptt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
